FILE: src/rdds_pkg.sv
`default_nettype none
package rdds_pkg;

  localparam int unsigned MaxSize   = 1024;
  localparam int unsigned SizeW     = 11;
  localparam int unsigned CoordW    = 10;
  localparam int unsigned NoiseW    = 16;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned D2W       = 22;
  localparam int unsigned RootW     = 27;
  localparam int unsigned QW        = 17;
  localparam int unsigned SqStages  = 27;
  localparam int unsigned DivStages = 17;

  localparam logic [QW-1:0]  QOne      = 17'h10000;
  localparam logic [15:0]    NoiseGain = 16'd9830;
  localparam logic [12:0]    NoiseHalf = 13'd4915;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DISC_SIZE  = 2'd0,
    CFG_BASE_RED   = 2'd1,
    CFG_BASE_GREEN = 2'd2,
    CFG_BASE_BLUE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [NoiseW-1:0] noise_sample;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } pix_out_t;

  function automatic logic [ChanW-1:0] dark_of(input logic [ChanW-1:0] b);
    logic [ChanW+1:0] t;
    logic [ChanW+9:0] m;
    begin
      t = {2'b00, b} + {1'b0, b, 1'b0};
      m = {8'd0, t} * 18'd205;
      dark_of = {1'b0, m[ChanW+9:11]};
    end
  endfunction

endpackage
`default_nettype wire

FILE: src/rdds_if.sv
`default_nettype none
interface rdds_in_if;
  import rdds_pkg::*;
  logic    valid;
  logic    ready;
  pix_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rdds_out_if;
  import rdds_pkg::*;
  logic     valid;
  logic     ready;
  pix_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/radial_disc_dither_shader_top.sv
// pipeline stages from input transaction to result: geometry 1, square root 27, divide 17,
// shading 5
// throughput: one pixel per cycle; every stage advances together and holds on a stall
// each stage carries its own valid bit; stages through the divider carry size, shading carries base colour
// reset: asynchronous, active low; valid bits cleared, config registers back to size 64, base white
`default_nettype none
module radial_disc_dither_shader_top (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [rdds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rdds_pkg::CfgDataW-1:0] cfg_data_i,
  rdds_in_if.sink                      in_if,
  rdds_out_if.source                   out_if
);
  import rdds_pkg::*;

  localparam int unsigned NStg = SqStages + DivStages + 6;

  logic [SizeW-1:0] size_q;
  logic [ChanW-1:0] br_q, bg_q, bb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 11'd64;
      br_q   <= 8'd255;
      bg_q   <= 8'd255;
      bb_q   <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DISC_SIZE:  size_q <= cfg_data_i;
        CFG_BASE_RED:   br_q   <= cfg_data_i[ChanW-1:0];
        CFG_BASE_GREEN: bg_q   <= cfg_data_i[ChanW-1:0];
        CFG_BASE_BLUE:  bb_q   <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  logic [NStg-1:0] vld_q;
  logic            adv;
  assign adv        = !vld_q[NStg-1] || out_if.ready;
  assign in_if.ready = adv;

  logic [SizeW-1:0] s_eff;
  assign s_eff = (size_q > SizeW'(MaxSize)) ? SizeW'(MaxSize) : size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_if.valid};
    end
  end

  // stage 0: geometry
  logic signed [SizeW+1:0] dx, dy;
  logic signed [2*SizeW+3:0] dxx, dyy;
  logic [D2W:0]            d2, ss;
  logic [D2W-1:0]          d2_q;
  logic                    in_q0;
  logic [SizeW-1:0]        s0_q;
  logic [NoiseW-1:0]       n0_q;
  logic [ChanW-1:0]        r0_q, g0_q, b0_q;
  always_comb begin
    dx  = $signed({2'b00, in_if.data.pixel_x, 1'b0}) - $signed({2'b00, s_eff});
    dy  = $signed({2'b00, in_if.data.pixel_y, 1'b0}) - $signed({2'b00, s_eff});
    dxx = dx * dx;
    dyy = dy * dy;
    d2  = (D2W+1)'($unsigned(dxx)) + (D2W+1)'($unsigned(dyy));
    ss  = (D2W+1)'(s_eff) * (D2W+1)'(s_eff);
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_q  <= d2[D2W-1:0];
      in_q0 <= (s_eff != '0) && (d2 <= ss);
      s0_q  <= s_eff;
      n0_q  <= in_if.data.noise_sample;
      r0_q  <= br_q;
      g0_q  <= bg_q;
      b0_q  <= bb_q;
    end
  end

  // square root of d2 << 32, one result bit per stage
  localparam int unsigned RadW = 2*RootW;
  logic [RadW-1:0]  sq_rem_q  [SqStages+1];
  logic [RootW-1:0] sq_root_q [SqStages+1];
  logic [RadW-1:0]  sq_val_q  [SqStages+1];
  logic             sq_in_q   [SqStages+1];
  logic [SizeW-1:0] sq_s_q    [SqStages+1];
  logic [NoiseW-1:0] sq_n_q   [SqStages+1];
  logic [ChanW-1:0] sq_r_q [SqStages+1], sq_g_q [SqStages+1], sq_b_q [SqStages+1];

  always_comb begin
    sq_rem_q[0]  = '0;
    sq_root_q[0] = '0;
    sq_val_q[0]  = {d2_q, 32'd0};
    sq_in_q[0]   = in_q0;
    sq_s_q[0]    = s0_q;
    sq_n_q[0]    = n0_q;
    sq_r_q[0]    = r0_q;
    sq_g_q[0]    = g0_q;
    sq_b_q[0]    = b0_q;
  end

  for (genvar k = 0; k < SqStages; k++) begin : g_sq
    logic [RadW-1:0]  rem_sh, trial;
    logic [RootW-1:0] root_n;
    logic [RadW-1:0]  rem_n;
    always_comb begin
      rem_sh = {sq_rem_q[k][RadW-3:0], sq_val_q[k][RadW-1:RadW-2]};
      trial  = {sq_root_q[k], 2'b01};
      if (rem_sh >= trial) begin
        rem_n  = rem_sh - trial;
        root_n = {sq_root_q[k][RootW-2:0], 1'b1};
      end else begin
        rem_n  = rem_sh;
        root_n = {sq_root_q[k][RootW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[k+1]  <= rem_n;
        sq_root_q[k+1] <= root_n;
        sq_val_q[k+1]  <= {sq_val_q[k][RadW-3:0], 2'b00};
        sq_in_q[k+1]   <= sq_in_q[k];
        sq_s_q[k+1]    <= sq_s_q[k];
        sq_n_q[k+1]    <= sq_n_q[k];
        sq_r_q[k+1]    <= sq_r_q[k];
        sq_g_q[k+1]    <= sq_g_q[k];
        sq_b_q[k+1]    <= sq_b_q[k];
      end
    end
  end

  // restoring division root / s, one quotient bit per stage; quotient below 2^17
  localparam int unsigned DRemW = SizeW + 1;
  logic [DRemW-1:0] dv_rem_q [DivStages+1];
  logic [RootW-1:0] dv_num_q [DivStages+1];
  logic [QW-1:0]    dv_q_q   [DivStages+1];
  logic             dv_in_q  [DivStages+1];
  logic [SizeW-1:0] dv_s_q   [DivStages+1];
  logic [NoiseW-1:0] dv_n_q  [DivStages+1];
  logic [ChanW-1:0] dv_r_q [DivStages+1], dv_g_q [DivStages+1], dv_b_q [DivStages+1];

  always_comb begin
    dv_rem_q[0] = DRemW'(sq_root_q[SqStages][RootW-1:QW]);
    dv_num_q[0] = {sq_root_q[SqStages][QW-1:0], 10'd0};
    dv_q_q[0]   = '0;
    dv_in_q[0]  = sq_in_q[SqStages];
    dv_s_q[0]   = sq_s_q[SqStages];
    dv_n_q[0]   = sq_n_q[SqStages];
    dv_r_q[0]   = sq_r_q[SqStages];
    dv_g_q[0]   = sq_g_q[SqStages];
    dv_b_q[0]   = sq_b_q[SqStages];
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_dv
    logic [DRemW:0]   rsh;
    logic [DRemW-1:0] rn;
    logic             qb;
    always_comb begin
      rsh = {dv_rem_q[k], dv_num_q[k][RootW-1]};
      qb  = rsh >= (DRemW+1)'(dv_s_q[k]);
      rn  = qb ? DRemW'(rsh - (DRemW+1)'(dv_s_q[k])) : DRemW'(rsh);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[k+1] <= rn;
        dv_num_q[k+1] <= {dv_num_q[k][RootW-2:0], 1'b0};
        dv_q_q[k+1]   <= {dv_q_q[k][QW-2:0], qb};
        dv_in_q[k+1]  <= dv_in_q[k];
        dv_s_q[k+1]   <= dv_s_q[k];
        dv_n_q[k+1]   <= dv_n_q[k];
        dv_r_q[k+1]   <= dv_r_q[k];
        dv_g_q[k+1]   <= dv_g_q[k];
        dv_b_q[k+1]   <= dv_b_q[k];
      end
    end
  end

  // shading: gradient, square, cube, mix, blend
  logic [QW-1:0]    q_f;
  logic             in_f;
  logic [NoiseW-1:0] n_f;
  logic [ChanW-1:0] r_f, g_f, b_f;
  assign q_f  = dv_q_q[DivStages];
  assign in_f = dv_in_q[DivStages];
  assign n_f  = dv_n_q[DivStages];
  assign r_f  = dv_r_q[DivStages];
  assign g_f  = dv_g_q[DivStages];
  assign b_f  = dv_b_q[DivStages];

  logic [QW-1:0]    g1_q;
  logic [15:0]      nt1_q;
  logic             in1_q;
  logic [ChanW-1:0] r1_q, gc1_q, b1_q;
  logic [31:0]      nmul;
  assign nmul = n_f * NoiseGain;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1_q  <= QOne - ((q_f > QOne) ? QOne : q_f);
      nt1_q <= nmul[31:16];
      in1_q <= in_f;
      r1_q  <= r_f;
      gc1_q <= g_f;
      b1_q  <= b_f;
    end
  end

  logic [2*QW-1:0]  sqr;
  assign sqr = g1_q * g1_q;
  logic [QW-1:0]    g2_q, g12_q;
  logic [15:0]      nt2_q;
  logic             in2_q;
  logic [ChanW-1:0] r2_q, gc2_q, b2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      g2_q  <= sqr[2*QW-2:16];
      g12_q <= g1_q;
      nt2_q <= nt1_q;
      in2_q <= in1_q;
      r2_q  <= r1_q;
      gc2_q <= gc1_q;
      b2_q  <= b1_q;
    end
  end

  logic [2*QW-1:0]  cub;
  assign cub = g2_q * g12_q;
  logic [QW-1:0]    g3_q;
  logic [15:0]      nt3_q;
  logic             in3_q;
  logic [ChanW-1:0] r3_q, gc3_q, b3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      g3_q  <= cub[2*QW-2:16];
      nt3_q <= nt2_q;
      in3_q <= in2_q;
      r3_q  <= r2_q;
      gc3_q <= gc2_q;
      b3_q  <= b2_q;
    end
  end

  logic signed [QW+1:0] mx;
  logic [QW-1:0]        mix_q;
  logic                 in4_q;
  logic [ChanW-1:0]     r4_q, gc4_q, b4_q, dr4_q, dg4_q, db4_q;
  assign mx = $signed({2'b00, g3_q}) + $signed({3'b000, nt3_q})
            - $signed({6'd0, NoiseHalf});
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (mx < 0) mix_q <= '0;
      else if (mx > $signed({2'b00, QOne})) mix_q <= QOne;
      else mix_q <= mx[QW-1:0];
      in4_q <= in3_q;
      r4_q  <= r3_q;
      gc4_q <= gc3_q;
      b4_q  <= b3_q;
      dr4_q <= dark_of(r3_q);
      dg4_q <= dark_of(gc3_q);
      db4_q <= dark_of(b3_q);
    end
  end

  logic [ChanW+QW-1:0] pr, pg, pb;
  assign pr = (r4_q - dr4_q) * mix_q;
  assign pg = (gc4_q - dg4_q) * mix_q;
  assign pb = (b4_q - db4_q) * mix_q;
  pix_out_t res_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (in4_q) begin
        res_q.red   <= dr4_q + pr[ChanW+15:16];
        res_q.green <= dg4_q + pg[ChanW+15:16];
        res_q.blue  <= db4_q + pb[ChanW+15:16];
        res_q.alpha <= 8'd255;
      end else begin
        res_q <= '0;
      end
    end
  end

  assign out_if.valid = vld_q[NStg-1];
  assign out_if.data  = res_q;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> $stable(res_q))
    else $error("result changed under stall");
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (res_q.alpha == 8'd255 || res_q == '0))
    else $error("alpha inconsistent");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("pipeline stalled without reason");
`endif

endmodule
`default_nettype wire
